/* src/qbmc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the quadratic Bezier maximum-curvature block.
// No dependencies; imported by qbmc_half and the top level.
package qbmc_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int CURV_WIDTH_DEF  = 32;

    localparam int COORD_FRAC = 12;
    localparam int CURV_FRAC  = 16;
    localparam int LEN_FRAC   = 4;

    // numerator alignment: interior L^3 and edge |C|
    localparam int SHIFT_INT  = COORD_FRAC + CURV_FRAC - 1 - 3 * LEN_FRAC;
    localparam int SHIFT_EDGE = COORD_FRAC + CURV_FRAC - 1 + 3 * LEN_FRAC;

    // partial-product slice width of the pipelined multipliers
    localparam int CHUNK = 16;

    typedef struct packed {
        logic valid;
        logic ovf;
        logic inter;
    } t_half_status;

endpackage

/* src/qbmc_half.sv */
`timescale 1ns / 1ps
// Curvature pipeline for one Bezier half: geometry, root, cube, divide.
// Depends on qbmc_pkg.
module qbmc_half
    import qbmc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int CURV_WIDTH  = CURV_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_p0x,
    input  logic signed [COORD_WIDTH-1:0] i_p0y,
    input  logic signed [COORD_WIDTH-1:0] i_p1x,
    input  logic signed [COORD_WIDTH-1:0] i_p1y,
    input  logic signed [COORD_WIDTH-1:0] i_p2x,
    input  logic signed [COORD_WIDTH-1:0] i_p2y,
    output t_half_status                  o_status,
    output logic [CURV_WIDTH-1:0]         o_curvature
);

    localparam int W    = COORD_WIDTH;
    localparam int CVW  = CURV_WIDTH;
    localparam int DW   = W + 1;
    localparam int QW   = W + 3;
    localparam int VW   = W + 2;
    localparam int PW   = 2 * DW;
    localparam int XW   = PW + 1;
    localparam int CW   = 2 * W + 2;
    localparam int RRW  = 2 * DW;
    localparam int Q2W  = 2 * QW;
    localparam int V2W  = 2 * VW;
    localparam int SXW  = V2W + 2 * LEN_FRAC;
    localparam int TW   = SXW + 1;
    localparam int LW   = SXW / 2;
    localparam int C2W  = 2 * CW;
    localparam int L2W  = 2 * LW;
    localparam int L3W  = 3 * LW;
    localparam int NCC  = (CW + CHUNK - 1) / CHUNK;
    localparam int NLC  = (LW + CHUNK - 1) / CHUNK;
    localparam int NWI  = L3W + SHIFT_INT;
    localparam int NWE  = CW + SHIFT_EDGE;
    localparam int NW   = (NWI > NWE) ? NWI : NWE;
    localparam int DNW  = (C2W > L3W) ? C2W : L3W;
    localparam int KW   = (NW > DNW) ? NW : DNW;
    localparam int RW   = DNW + 1;

    // ---------------- stage 1: differences ----------------
    logic signed [DW-1:0] n_ex, n_ey, n_fx, n_fy, n_rx, n_ry;
    logic signed [QW-1:0] n_ax, n_ay, n_bx, n_by;
    logic signed [VW-1:0] n_vx, n_vy;
    logic signed [DW-1:0] r1_ex, r1_ey, r1_fx, r1_fy, r1_rx, r1_ry;
    logic signed [QW-1:0] r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [VW-1:0] r1_vx, r1_vy;
    logic                 r1_v;

    assign n_ex = DW'(i_p0x) - DW'(i_p1x);
    assign n_ey = DW'(i_p0y) - DW'(i_p1y);
    assign n_fx = DW'(i_p2x) - DW'(i_p1x);
    assign n_fy = DW'(i_p2y) - DW'(i_p1y);
    assign n_rx = DW'(i_p2x) - DW'(i_p0x);
    assign n_ry = DW'(i_p2y) - DW'(i_p0y);
    // quarter-point tests: 4P1-3P0-P2 and 4P1-P0-3P2
    assign n_ax = (QW'(i_p1x) <<< 2) - (QW'(i_p0x) <<< 1) - QW'(i_p0x) - QW'(i_p2x);
    assign n_ay = (QW'(i_p1y) <<< 2) - (QW'(i_p0y) <<< 1) - QW'(i_p0y) - QW'(i_p2y);
    assign n_bx = (QW'(i_p1x) <<< 2) - QW'(i_p0x) - (QW'(i_p2x) <<< 1) - QW'(i_p2x);
    assign n_by = (QW'(i_p1y) <<< 2) - QW'(i_p0y) - (QW'(i_p2y) <<< 1) - QW'(i_p2y);
    // 2*(M-P1)
    assign n_vx = VW'(i_p0x) + VW'(i_p2x) - (VW'(i_p1x) <<< 1);
    assign n_vy = VW'(i_p0y) + VW'(i_p2y) - (VW'(i_p1y) <<< 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ex <= n_ex; r1_ey <= n_ey; r1_fx <= n_fx; r1_fy <= n_fy;
            r1_rx <= n_rx; r1_ry <= n_ry;
            r1_ax <= n_ax; r1_ay <= n_ay; r1_bx <= n_bx; r1_by <= n_by;
            r1_vx <= n_vx; r1_vy <= n_vy;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [PW-1:0]  n_pa, n_pb, n_exx, n_eyy, n_fxx, n_fyy, n_rxx, n_ryy;
    logic signed [Q2W-1:0] n_axx, n_ayy, n_bxx, n_byy;
    logic signed [V2W-1:0] n_vxx, n_vyy;
    logic signed [PW-1:0]  r2_pa, r2_pb, r2_exx, r2_eyy, r2_fxx, r2_fyy, r2_rxx, r2_ryy;
    logic signed [Q2W-1:0] r2_axx, r2_ayy, r2_bxx, r2_byy;
    logic signed [V2W-1:0] r2_vxx, r2_vyy;
    logic                  r2_v;

    assign n_pa  = r1_ex * r1_fy;
    assign n_pb  = r1_ey * r1_fx;
    assign n_exx = r1_ex * r1_ex;
    assign n_eyy = r1_ey * r1_ey;
    assign n_fxx = r1_fx * r1_fx;
    assign n_fyy = r1_fy * r1_fy;
    assign n_rxx = r1_rx * r1_rx;
    assign n_ryy = r1_ry * r1_ry;
    assign n_axx = r1_ax * r1_ax;
    assign n_ayy = r1_ay * r1_ay;
    assign n_bxx = r1_bx * r1_bx;
    assign n_byy = r1_by * r1_by;
    assign n_vxx = r1_vx * r1_vx;
    assign n_vyy = r1_vy * r1_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pa <= n_pa; r2_pb <= n_pb;
            r2_exx <= n_exx; r2_eyy <= n_eyy; r2_fxx <= n_fxx; r2_fyy <= n_fyy;
            r2_rxx <= n_rxx; r2_ryy <= n_ryy;
            r2_axx <= n_axx; r2_ayy <= n_ayy; r2_bxx <= n_bxx; r2_byy <= n_byy;
            r2_vxx <= n_vxx; r2_vyy <= n_vyy;
        end
    end

    // ---------------- stage 3: sums ----------------
    logic signed [XW-1:0] r3_cross;
    logic [RRW-1:0]       r3_rr, r3_se, r3_sf;
    logic [Q2W-1:0]       r3_d0, r3_d2;
    logic [V2W-1:0]       r3_sv;
    logic                 r3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_cross <= XW'(r2_pa) - XW'(r2_pb);
            r3_rr    <= $unsigned(r2_rxx) + $unsigned(r2_ryy);
            r3_se    <= $unsigned(r2_exx) + $unsigned(r2_eyy);
            r3_sf    <= $unsigned(r2_fxx) + $unsigned(r2_fyy);
            r3_d0    <= $unsigned(r2_axx) + $unsigned(r2_ayy);
            r3_d2    <= $unsigned(r2_bxx) + $unsigned(r2_byy);
            r3_sv    <= $unsigned(r2_vxx) + $unsigned(r2_vyy);
        end
    end

    // ---------------- stage 4: formula choice ----------------
    logic            n_inter;
    logic [CW-1:0]   n_cm;
    logic [RRW-1:0]  n_g;
    logic [V2W-1:0]  n_sq;
    logic            r4_inter;
    logic [CW-1:0]   r4_cm;
    logic [SXW-1:0]  r4_sqin;
    logic            r4_v;

    assign n_inter = (r3_d0 > Q2W'(r3_rr)) && (r3_d2 > Q2W'(r3_rr));
    assign n_cm    = r3_cross[XW-1] ? CW'(-r3_cross) : CW'(r3_cross);
    assign n_g     = (r3_se < r3_sf) ? r3_se : r3_sf;
    assign n_sq    = n_inter ? r3_sv : V2W'(n_g);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_inter <= n_inter;
            r4_cm    <= n_cm;
            r4_sqin  <= SXW'(n_sq) << (2 * LEN_FRAC);
        end
    end

    // ---------------- square root, one bit a stage; C^2 built alongside ----------------
    logic [SXW-1:0] r_rem  [1:LW];
    logic [LW-1:0]  r_root [1:LW];
    logic [CW-1:0]  r_scm  [1:LW];
    logic [C2W-1:0] r_sc2  [1:LW];
    logic           r_sint [1:LW];
    logic           r_sv   [1:LW];

    for (genvar s = 0; s < LW; s++) begin : g_sqrt
        localparam int B = LW - 1 - s;
        logic [SXW-1:0]       rem_i;
        logic [LW-1:0]        root_i;
        logic [CW-1:0]        cm_i;
        logic [C2W-1:0]       c2_i;
        logic                 int_i, v_i;
        logic [TW-1:0]        trial;
        logic                 ge;
        logic [SXW-1:0]       n_rem;
        logic [LW-1:0]        n_root;
        logic [C2W-1:0]       n_c2;

        if (s == 0) begin : g_first
            assign rem_i  = r4_sqin;
            assign root_i = '0;
            assign cm_i   = r4_cm;
            assign c2_i   = '0;
            assign int_i  = r4_inter;
            assign v_i    = r4_v;
        end else begin : g_next
            assign rem_i  = r_rem[s];
            assign root_i = r_root[s];
            assign cm_i   = r_scm[s];
            assign c2_i   = r_sc2[s];
            assign int_i  = r_sint[s];
            assign v_i    = r_sv[s];
        end

        assign trial  = (TW'(root_i) << (B + 1)) + (TW'(1) << (2 * B));
        assign ge     = TW'(rem_i) >= trial;
        assign n_rem  = ge ? rem_i - SXW'(trial) : rem_i;
        assign n_root = ge ? (root_i | (LW'(1) << B)) : root_i;

        if (s < NCC) begin : g_c2
            logic [NCC*CHUNK-1:0]  cm_pad;
            logic [CHUNK-1:0]      slice;
            logic [CW+CHUNK-1:0]   pp;
            assign cm_pad = (NCC * CHUNK)'(cm_i);
            assign slice  = cm_pad[CHUNK*s +: CHUNK];
            assign pp     = cm_i * slice;
            assign n_c2   = c2_i + (C2W'(pp) << (CHUNK * s));
        end else begin : g_c2_hold
            assign n_c2 = c2_i;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[s+1] <= v_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_rem;
                r_root[s+1] <= n_root;
                r_scm[s+1]  <= cm_i;
                r_sc2[s+1]  <= n_c2;
                r_sint[s+1] <= int_i;
            end
        end
    end

    // ---------------- cube: L^2 then L^3, one slice of L a stage ----------------
    localparam int NCS = 2 * NLC;
    logic [LW-1:0]  r_len [1:NCS];
    logic [L2W-1:0] r_l2  [1:NCS];
    logic [L3W-1:0] r_l3  [1:NCS];
    logic [CW-1:0]  r_ccm [1:NCS];
    logic [C2W-1:0] r_cc2 [1:NCS];
    logic           r_cint[1:NCS];
    logic           r_cv  [1:NCS];

    for (genvar k = 0; k < NCS; k++) begin : g_cube
        localparam int J = (k < NLC) ? k : k - NLC;
        logic [LW-1:0]         len_i;
        logic [L2W-1:0]        l2_i, n_l2;
        logic [L3W-1:0]        l3_i, n_l3;
        logic [CW-1:0]         cm_i;
        logic [C2W-1:0]        c2_i;
        logic                  int_i, v_i;
        logic [NLC*CHUNK-1:0]  len_pad;
        logic [CHUNK-1:0]      slice;

        if (k == 0) begin : g_first
            assign len_i = r_root[LW];
            assign l2_i  = '0;
            assign l3_i  = '0;
            assign cm_i  = r_scm[LW];
            assign c2_i  = r_sc2[LW];
            assign int_i = r_sint[LW];
            assign v_i   = r_sv[LW];
        end else begin : g_next
            assign len_i = r_len[k];
            assign l2_i  = r_l2[k];
            assign l3_i  = r_l3[k];
            assign cm_i  = r_ccm[k];
            assign c2_i  = r_cc2[k];
            assign int_i = r_cint[k];
            assign v_i   = r_cv[k];
        end

        assign len_pad = (NLC * CHUNK)'(len_i);
        assign slice   = len_pad[CHUNK*J +: CHUNK];

        if (k < NLC) begin : g_sq
            logic [LW+CHUNK-1:0] pp;
            assign pp   = len_i * slice;
            assign n_l2 = l2_i + (L2W'(pp) << (CHUNK * J));
            assign n_l3 = l3_i;
        end else begin : g_cb
            logic [L2W+CHUNK-1:0] pp;
            assign pp   = l2_i * slice;
            assign n_l2 = l2_i;
            assign n_l3 = l3_i + (L3W'(pp) << (CHUNK * J));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_cv[k+1] <= v_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[k+1]  <= len_i;
                r_l2[k+1]   <= n_l2;
                r_l3[k+1]   <= n_l3;
                r_ccm[k+1]  <= cm_i;
                r_cc2[k+1]  <= c2_i;
                r_cint[k+1] <= int_i;
            end
        end
    end

    // ---------------- operand select ----------------
    logic [NW-1:0]  r5_num;
    logic [DNW-1:0] r5_den;
    logic           r5_int, r5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= r_cv[NCS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_int <= r_cint[NCS];
            if (r_cint[NCS]) begin
                r5_num <= NW'(r_l3[NCS]) << SHIFT_INT;
                r5_den <= DNW'(r_cc2[NCS]);
            end else begin
                r5_num <= NW'(r_ccm[NCS]) << SHIFT_EDGE;
                r5_den <= DNW'(r_l3[NCS]);
            end
        end
    end

    // ---------------- saturation check, also catches a zero divisor ----------------
    logic [RW-1:0]  r6_rem;
    logic [CVW-1:0] r6_low;
    logic [DNW-1:0] r6_den;
    logic           r6_ovf, r6_int, r6_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (i_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_ovf <= KW'(r5_num >> CVW) >= KW'(r5_den);
            r6_rem <= RW'(r5_num >> CVW);
            r6_low <= r5_num[CVW-1:0];
            r6_den <= r5_den;
            r6_int <= r5_int;
        end
    end

    // ---------------- restoring divide, one quotient bit a stage ----------------
    logic [RW-1:0]  r_drem[1:CVW];
    logic [CVW-1:0] r_q   [1:CVW];
    logic [CVW-1:0] r_dlow[1:CVW];
    logic [DNW-1:0] r_dden[1:CVW];
    logic           r_dovf[1:CVW];
    logic           r_dint[1:CVW];
    logic           r_dv  [1:CVW];

    for (genvar s = 0; s < CVW; s++) begin : g_div
        logic [RW-1:0]  rem_i, t, n_rem;
        logic [CVW-1:0] q_i, low_i;
        logic [DNW-1:0] den_i;
        logic           ovf_i, int_i, v_i, ge;

        if (s == 0) begin : g_first
            assign rem_i = r6_rem;
            assign q_i   = '0;
            assign low_i = r6_low;
            assign den_i = r6_den;
            assign ovf_i = r6_ovf;
            assign int_i = r6_int;
            assign v_i   = r6_v;
        end else begin : g_next
            assign rem_i = r_drem[s];
            assign q_i   = r_q[s];
            assign low_i = r_dlow[s];
            assign den_i = r_dden[s];
            assign ovf_i = r_dovf[s];
            assign int_i = r_dint[s];
            assign v_i   = r_dv[s];
        end

        assign t     = {rem_i[RW-2:0], low_i[CVW-1-s]};
        assign ge    = t >= RW'(den_i);
        assign n_rem = ge ? t - RW'(den_i) : t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[s+1] <= v_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[s+1] <= n_rem;
                r_q[s+1]    <= {q_i[CVW-2:0], ge};
                r_dlow[s+1] <= low_i;
                r_dden[s+1] <= den_i;
                r_dovf[s+1] <= ovf_i;
                r_dint[s+1] <= int_i;
            end
        end
    end

    assign o_curvature    = r_dovf[CVW] ? '1 : r_q[CVW];
    assign o_status.valid = r_dv[CVW];
    assign o_status.ovf   = r_dovf[CVW];
    assign o_status.inter = r_dint[CVW];

endmodule

/* src/quadratic_bezier_max_curvature.sv */
`timescale 1ns / 1ps
// Top level: maximum curvature of two quadratic Bezier halves sharing P0.
// Depends on qbmc_pkg and qbmc_half.
//
//  channel | dir | tdata (lowest bit first)                      | tuser
//  --------+-----+-----------------------------------------------+---------------------------
//  s_axis  | in  | P0x P0y, P1x P1y P2x P2y of half 1, then half 2 | -
//  m_axis  | out | first_curvature, second_curvature (Q16.16)    | ovf1 ovf2 int1 int2
//
// One beat enters every cycle unless the pipeline is frozen; the root and divide are
// bit-serial pipelines. The whole pipeline advances together: it freezes only while the
// output register holds a beat that is not taken, so nothing is lost or repeated.
// Reset (synchronous, active low) clears only the valid bits.
module quadratic_bezier_max_curvature
    import qbmc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int CURV_WIDTH  = CURV_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // shared_point_x, shared_point_y, first_middle_x, first_middle_y, first_end_x,
    // first_end_y, second_middle_x, second_middle_y, second_end_x, second_end_y, zero pad
    input  logic [((10*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // first_curvature, second_curvature, zero pad
    output logic [((2*CURV_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // first_overflow, second_overflow, first_interior, second_interior
    output logic [3:0]                            m_axis_tuser
);

    localparam int W   = COORD_WIDTH;
    localparam int ODW = ((2 * CURV_WIDTH + 7) / 8) * 8;

    logic                  w_en;
    t_half_status          w_st0, w_st1;
    logic [CURV_WIDTH-1:0] w_c0, w_c1;

    // pipeline moves unless the output beat is stuck
    assign w_en          = !w_st0.valid || m_axis_tready;
    assign s_axis_tready = w_en;

    qbmc_half #(
        .COORD_WIDTH(COORD_WIDTH),
        .CURV_WIDTH (CURV_WIDTH)
    ) u_first (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (s_axis_tvalid),
        .i_p0x      (s_axis_tdata[0*W +: W]),
        .i_p0y      (s_axis_tdata[1*W +: W]),
        .i_p1x      (s_axis_tdata[2*W +: W]),
        .i_p1y      (s_axis_tdata[3*W +: W]),
        .i_p2x      (s_axis_tdata[4*W +: W]),
        .i_p2y      (s_axis_tdata[5*W +: W]),
        .o_status   (w_st0),
        .o_curvature(w_c0)
    );

    qbmc_half #(
        .COORD_WIDTH(COORD_WIDTH),
        .CURV_WIDTH (CURV_WIDTH)
    ) u_second (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (s_axis_tvalid),
        .i_p0x      (s_axis_tdata[0*W +: W]),
        .i_p0y      (s_axis_tdata[1*W +: W]),
        .i_p1x      (s_axis_tdata[6*W +: W]),
        .i_p1y      (s_axis_tdata[7*W +: W]),
        .i_p2x      (s_axis_tdata[8*W +: W]),
        .i_p2y      (s_axis_tdata[9*W +: W]),
        .o_status   (w_st1),
        .o_curvature(w_c1)
    );

    assign m_axis_tvalid = w_st0.valid;
    assign m_axis_tdata  = ODW'({w_c1, w_c0});
    assign m_axis_tuser  = {w_st1.inter, w_st0.inter, w_st1.ovf, w_st0.ovf};

    // both halves run in lockstep
    a_halves_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st0.valid == w_st1.valid)
        else $error("curvature halves out of step");

    // a saturated result reads all ones
    a_sat_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (&m_axis_tdata[CURV_WIDTH-1:0]))
        else $error("first overflow without saturation");

    // a held output beat freezes the input side
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
